// File: design/gdn_pkg.sv
// Shared widths, calendar constants and the month offset table for the day number converter.
package gdn_pkg;

    // Number of register stages from the input port to the output register.
    localparam int STAGES = 12;

    localparam int CNT_W  = 41;
    localparam int YEAR_W = 32;
    localparam int MON_W  = 4;
    localparam int MDAY_W = 5;

    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [YEAR_W-1:0] t_year;
    typedef logic [MON_W-1:0]  t_month;
    typedef logic [MDAY_W-1:0] t_mday;

    // Calendar constants.
    localparam int DAYS_400Y     = 146097;
    localparam int DAYS_4Y       = 1461;
    localparam int DAYS_YEAR     = 365;
    localparam int DAYS_LEAPYEAR = 366;
    localparam int MONTHS        = 12;
    localparam int YEARS_400     = 400;

    // Day offset of a month, indexed by the month minus one. Years are counted from
    // March for months after February, so those offsets fall below zero and wrap.
    function automatic t_count month_offset(input logic [3:0] idx);
        t_count off;
        case (idx)
            4'd0:    off = t_count'(0);
            4'd1:    off = t_count'(31);
            4'd2:    off = t_count'(-306);
            4'd3:    off = t_count'(-275);
            4'd4:    off = t_count'(-245);
            4'd5:    off = t_count'(-214);
            4'd6:    off = t_count'(-184);
            4'd7:    off = t_count'(-153);
            4'd8:    off = t_count'(-122);
            4'd9:    off = t_count'(-92);
            4'd10:   off = t_count'(-61);
            4'd11:   off = t_count'(-31);
            default: off = t_count'(0);
        endcase
        return off;
    endfunction

endpackage

// File: design/gdn_cdiv.sv
// Four stage pipelined division of an unsigned value by a constant, via a reciprocal.
module gdn_cdiv #(
    parameter int WIDTH   = 32,
    parameter int DIVISOR = 12
) (
    input  logic                                i_clk,
    input  logic [3:0]                          i_load,
    input  logic [WIDTH-1:0]                    i_x,
    output logic [WIDTH-$clog2(DIVISOR):0]      o_q,
    output logic [$clog2(DIVISOR)-1:0]          o_r
);

    localparam int RW = $clog2(DIVISOR);
    localparam int QW = WIDTH - RW + 1;
    localparam int MW = QW;
    localparam int DW = $clog2(DIVISOR + 1);
    localparam int LW = WIDTH / 2;
    localparam int HW = WIDTH - LW;
    localparam int FW = WIDTH + MW;

    localparam logic [MW-1:0] MUL = MW'((64'd1 << WIDTH) / DIVISOR);
    localparam logic [DW-1:0] DIV = DW'(DIVISOR);

    logic [LW+MW-1:0] r_pl;
    logic [HW+MW-1:0] r_ph;
    logic [WIDTH-1:0] r_xa;
    logic [QW-1:0]    r_qb;
    logic [WIDTH-1:0] r_xb;
    logic [QW-1:0]    r_qc;
    logic [RW:0]      r_rc;
    logic [QW-1:0]    r_q;
    logic [RW-1:0]    r_r;

    logic [FW-1:0]    full;
    logic [WIDTH-1:0] back;
    logic [WIDTH-1:0] diff;

    // Stage a: two partial products of the value and the reciprocal.
    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_pl <= (LW+MW)'(i_x[LW-1:0]) * (LW+MW)'(MUL);
            r_ph <= (HW+MW)'(i_x[WIDTH-1:LW]) * (HW+MW)'(MUL);
            r_xa <= i_x;
        end
    end

    // Stage b: sum the partial products; the estimate is low by at most one.
    assign full = (FW'(r_ph) << LW) + FW'(r_pl);

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_qb <= full[FW-1:WIDTH];
            r_xb <= r_xa;
        end
    end

    // Stage c: remainder of the estimate, which stays below twice the divisor.
    assign back = WIDTH'((QW+DW)'(r_qb) * (QW+DW)'(DIV));
    assign diff = r_xb - back;

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r_qc <= r_qb;
            r_rc <= diff[RW:0];
        end
    end

    // Stage d: one correction step.
    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            if (r_rc >= (RW+1)'(DIV)) begin
                r_q <= r_qc + QW'(1);
                r_r <= RW'(r_rc - (RW+1)'(DIV));
            end else begin
                r_q <= r_qc;
                r_r <= r_rc[RW-1:0];
            end
        end
    end

    assign o_q = r_q;
    assign o_r = r_r;

endmodule

// File: design/gdn_d2c.sv
// Date to day count datapath: month carry, 400 year split and final sum.
module gdn_d2c import gdn_pkg::*; (
    input  logic              i_clk,
    input  logic [STAGES-1:1] i_load,
    input  t_year             i_year,
    input  logic [31:0]       i_month,
    input  logic [31:0]       i_mday,
    output t_count            o_count
);

    localparam int Q12_W  = 32 - $clog2(MONTHS) + 1;
    localparam int Q400_W = 33 - $clog2(YEARS_400) + 1;

    logic [31:0]   r_m1;
    t_year         r_yr   [1:5];
    logic [31:0]   r_dm   [1:5];
    logic          r_zero [1:10];
    logic [32:0]   r_y6;
    t_count        r_c    [6:10];
    t_count        r_a11;
    logic [17:0]   r_b11;
    t_count        r_c11;
    logic          r_zero11;

    logic [Q12_W-1:0]  q12;
    logic [3:0]        rem12;
    logic [Q400_W-1:0] q400;
    logic [8:0]        rem400;
    logic [32:0]       y6;
    t_count            c6;
    logic [1:0]        cent;
    logic [17:0]       b11;
    logic [42:0]       a11;

    // Stages 2 to 5: month split into carried years and month of year.
    gdn_cdiv #(.WIDTH(32), .DIVISOR(MONTHS)) u_div12 (
        .i_clk  (i_clk),
        .i_load (i_load[5:2]),
        .i_x    (r_m1),
        .o_q    (q12),
        .o_r    (rem12)
    );

    // Stage 6: year counted from March and the month plus day part of the sum.
    assign y6 = {1'b0, r_yr[5]} + 33'(q12) - 33'(rem12 <= 4'd1);
    assign c6 = month_offset(rem12) + t_count'(r_dm[5]) - t_count'(1);

    // Stages 7 to 10: whole 400 year cycles and the year within the cycle.
    gdn_cdiv #(.WIDTH(33), .DIVISOR(YEARS_400)) u_div400 (
        .i_clk  (i_clk),
        .i_load (i_load[10:7]),
        .i_x    (r_y6),
        .o_q    (q400),
        .o_r    (rem400)
    );

    // Registers of stages 1 to 10 that run beside the dividers. Stage 1 takes the
    // month counted from zero and the invalid date check.
    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_m1      <= i_month - 32'd1;
            r_yr[1]   <= i_year;
            r_dm[1]   <= i_mday;
            r_zero[1] <= (i_year == '0) || (i_month == '0) || (i_mday == '0);
        end
        for (int k = 2; k <= 5; k++) begin
            if (i_load[k]) begin
                r_yr[k]   <= r_yr[k-1];
                r_dm[k]   <= r_dm[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
        if (i_load[6]) begin
            r_y6      <= y6;
            r_c[6]    <= c6;
            r_zero[6] <= r_zero[5];
        end
        for (int k = 7; k <= 10; k++) begin
            if (i_load[k]) begin
                r_c[k]    <= r_c[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    // Stage 11: days in whole cycles and days in the years of the cycle.
    always_comb begin
        if (rem400 >= 9'd300) begin
            cent = 2'd3;
        end else if (rem400 >= 9'd200) begin
            cent = 2'd2;
        end else if (rem400 >= 9'd100) begin
            cent = 2'd1;
        end else begin
            cent = 2'd0;
        end
    end

    assign b11 = 18'(rem400) * 18'(DAYS_YEAR) + 18'(rem400[8:2]) - 18'(cent);
    assign a11 = 43'(q400) * 43'(DAYS_400Y);

    always_ff @(posedge i_clk) begin
        if (i_load[11]) begin
            r_a11    <= a11[CNT_W-1:0];
            r_b11    <= b11;
            r_c11    <= r_c[10];
            r_zero11 <= r_zero[10];
        end
    end

    // Final sum, wrapping at the count width.
    assign o_count = r_zero11 ? '0 : (r_a11 + t_count'(r_b11) + r_c11);

endmodule

// File: design/gdn_c2d.sv
// Day count to date datapath: cycle splits, leap corrections and month decode.
module gdn_c2d import gdn_pkg::*; (
    input  logic              i_clk,
    input  logic [STAGES-1:1] i_load,
    input  t_count            i_count,
    output t_year             o_year,
    output t_month            o_month,
    output t_mday             o_mday,
    output logic              o_sat
);

    localparam int Q400_W = CNT_W - $clog2(DAYS_400Y) + 1;
    localparam int Q4_W   = 18 - $clog2(DAYS_4Y) + 1;

    logic [17:0] r_c5;
    logic [32:0] r_y [5:10];
    logic [10:0] r_c10;
    logic [8:0]  r_d11;
    logic [32:0] r_y11;

    logic [Q400_W-1:0] q400;
    logic [17:0]       rem400;
    logic [1:0]        t5;
    logic [Q4_W-1:0]   q4;
    logic [10:0]       rem4;
    logic [1:0]        t10;
    logic [1:0]        q366;
    logic [10:0]       d11;
    logic [8:0]        e;
    t_month            m;

    // Stages 1 to 4: whole 400 year cycles and the day within the cycle.
    gdn_cdiv #(.WIDTH(CNT_W), .DIVISOR(DAYS_400Y)) u_div400 (
        .i_clk  (i_clk),
        .i_load (i_load[4:1]),
        .i_x    (i_count),
        .o_q    (q400),
        .o_r    (rem400)
    );

    // Stage 5: skip the missing leap days of the century years.
    always_comb begin
        if (rem400 >= 18'd109266) begin
            t5 = 2'd3;
        end else if (rem400 >= 18'd72742) begin
            t5 = 2'd2;
        end else if (rem400 >= 18'd36218) begin
            t5 = 2'd1;
        end else begin
            t5 = 2'd0;
        end
    end

    // Stages 6 to 9: whole four year groups.
    gdn_cdiv #(.WIDTH(18), .DIVISOR(DAYS_4Y)) u_div4y (
        .i_clk  (i_clk),
        .i_load (i_load[9:6]),
        .i_x    (r_c5),
        .o_q    (q4),
        .o_r    (rem4)
    );

    // Stage 10: pad the short years so that every year spans 366 days.
    always_comb begin
        if (rem4 >= 11'd789) begin
            t10 = 2'd3;
        end else if (rem4 >= 11'd424) begin
            t10 = 2'd2;
        end else if (rem4 >= 11'd59) begin
            t10 = 2'd1;
        end else begin
            t10 = 2'd0;
        end
    end

    // Registers of stages 5 to 10; the year rides beside the four year divider.
    always_ff @(posedge i_clk) begin
        if (i_load[5]) begin
            r_c5   <= rem400 + 18'(t5);
            r_y[5] <= 33'(q400) * 33'(YEARS_400) + 33'd1;
        end
        for (int k = 6; k <= 9; k++) begin
            if (i_load[k]) begin
                r_y[k] <= r_y[k-1];
            end
        end
        if (i_load[10]) begin
            r_c10   <= rem4 + 11'(t10);
            r_y[10] <= r_y[9] + (33'(q4) << 2);
        end
    end

    // Stage 11: year within the group and the day within the year.
    always_comb begin
        if (r_c10 >= 11'd1098) begin
            q366 = 2'd3;
        end else if (r_c10 >= 11'd732) begin
            q366 = 2'd2;
        end else if (r_c10 >= 11'd366) begin
            q366 = 2'd1;
        end else begin
            q366 = 2'd0;
        end
    end

    assign d11 = r_c10 - 11'(q366) * 11'(DAYS_LEAPYEAR);

    always_ff @(posedge i_clk) begin
        if (i_load[11]) begin
            r_d11 <= d11[8:0];
            r_y11 <= r_y[10] + 33'(q366);
        end
    end

    // Month decode: January and February, then five month runs from March.
    always_comb begin
        if (r_d11 >= 9'd60) begin
            e = r_d11 - 9'd60;
            m = t_month'(3);
            if (e >= 9'd153) begin
                e = e - 9'd153;
                m = m + t_month'(5);
            end
            if (e >= 9'd122) begin
                e = e - 9'd122;
                m = m + t_month'(4);
            end else if (e >= 9'd61) begin
                e = e - 9'd61;
                m = m + t_month'(2);
            end
        end else begin
            e = r_d11;
            m = t_month'(1);
        end
        if (e >= 9'd31) begin
            e = e - 9'd31;
            m = m + t_month'(1);
        end
    end

    // Clamp years that do not fit the output width.
    assign o_sat   = r_y11[32];
    assign o_year  = r_y11[32] ? '1 : r_y11[31:0];
    assign o_month = r_y11[32] ? t_month'(12) : m;
    assign o_mday  = r_y11[32] ? t_mday'(31) : (e[4:0] + t_mday'(1));

endmodule

// File: design/gregorian_day_number_converter.sv
// Proleptic Gregorian converter between calendar dates and day numbers.
//
// Input channel: i_valid/o_ready carry one request per beat. With i_req_type
// low the year, month and day of month are turned into the days elapsed since
// 1 January of year 1; a month above 12 carries into the year and a zero field
// gives a count of zero. With i_req_type high the day count is turned into
// year, month and day of month, clamped to 4294967295-12-31 with o_saturated
// set when the year does not fit. Fields of the other direction read as zero.
// Output channel: o_valid/i_ready carry one result per beat, in request order.
// Each accepted beat passes every stage to the output register. One beat is
// taken every cycle unless a stall holds it. The depth is set by the constant
// dividers: each runs a reciprocal product, a back product and a correction.
// Every stage holds its beat while the stage after it is full, so a stalled
// receiver fills the empty stages first and o_ready falls only when all 12
// are occupied. Reset clears every valid bit; no clearing pass is needed.
module gregorian_day_number_converter import gdn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_year_in,
    input  logic [31:0] i_month_in,
    input  logic [31:0] i_mday_in,
    input  logic [40:0] i_count_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [40:0] o_count_out,
    output logic [31:0] o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_mday_out,
    output logic        o_saturated
);

    logic [STAGES:1]   r_valid;
    logic              r_type [1:STAGES-1];
    t_count            r_count;
    t_year             r_year;
    t_month            r_month;
    t_mday             r_mday;
    logic              r_sat;

    logic [STAGES:1]   stage_load;
    t_count            d2c_count;
    t_year             c2d_year;
    t_month            c2d_month;
    t_mday             c2d_mday;
    logic              c2d_sat;

    // A stage loads when it is empty or the stage after it moves on.
    always_comb begin
        stage_load[STAGES] = !r_valid[STAGES] || i_ready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            stage_load[k] = !r_valid[k] || stage_load[k+1];
        end
    end

    assign o_ready = stage_load[1];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_load[1]) begin
                r_valid[1] <= i_valid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (stage_load[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Request type follows the beat down the pipeline.
    always_ff @(posedge i_clk) begin
        if (stage_load[1]) begin
            r_type[1] <= i_req_type;
        end
        for (int k = 2; k <= STAGES - 1; k++) begin
            if (stage_load[k]) begin
                r_type[k] <= r_type[k-1];
            end
        end
    end

    gdn_d2c u_d2c (
        .i_clk   (i_clk),
        .i_load  (stage_load[STAGES-1:1]),
        .i_year  (i_year_in),
        .i_month (i_month_in),
        .i_mday  (i_mday_in),
        .o_count (d2c_count)
    );

    gdn_c2d u_c2d (
        .i_clk   (i_clk),
        .i_load  (stage_load[STAGES-1:1]),
        .i_count (i_count_in),
        .o_year  (c2d_year),
        .o_month (c2d_month),
        .o_mday  (c2d_mday),
        .o_sat   (c2d_sat)
    );

    // Output register: pick the direction, zero the other fields.
    always_ff @(posedge i_clk) begin
        if (stage_load[STAGES]) begin
            if (r_type[STAGES-1]) begin
                r_count <= '0;
                r_year  <= c2d_year;
                r_month <= c2d_month;
                r_mday  <= c2d_mday;
                r_sat   <= c2d_sat;
            end else begin
                r_count <= d2c_count;
                r_year  <= '0;
                r_month <= '0;
                r_mday  <= '0;
                r_sat   <= 1'b0;
            end
        end
    end

    assign o_valid     = r_valid[STAGES];
    assign o_count_out = r_count;
    assign o_year_out  = r_year;
    assign o_month_out = r_month;
    assign o_mday_out  = r_mday;
    assign o_saturated = r_sat;

endmodule

// File: design/gdn_chk.sv
// Port level checker for the day number converter, bound to the top level.
module gdn_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_req_type,
    input logic [31:0] i_year_in,
    input logic [31:0] i_month_in,
    input logic [31:0] i_mday_in,
    input logic [40:0] i_count_in,
    input logic        o_valid,
    input logic        i_ready,
    input logic [40:0] o_count_out,
    input logic [31:0] o_year_out,
    input logic [3:0]  o_month_out,
    input logic [4:0]  o_mday_out,
    input logic        o_saturated
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat shown straight after reset");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_count_out) && $stable(o_year_out)
            && $stable(o_month_out) && $stable(o_mday_out) && $stable(o_saturated))
        else $error("stalled result beat changed");

    // A clamped date is always the last day of the largest year.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_year_out == 32'hFFFFFFFF && o_month_out == 4'd12
            && o_mday_out == 5'd31)
        else $error("saturated result is not the clamped date");

    // A non-zero count belongs to a date to count request, so the date fields are zero.
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_count_out != '0 |-> o_year_out == '0 && o_month_out == '0
            && o_mday_out == '0 && !o_saturated)
        else $error("both directions populated in one result");

    // A decoded date has a real month and day.
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_month_out != '0 |-> o_month_out <= 4'd12 && o_mday_out != '0)
        else $error("decoded date out of range");

endmodule

bind gregorian_day_number_converter gdn_chk u_gdn_chk (.*);
